// ===== rtl/selu_activation_fp32_defines.svh =====
// assertion macros for the selu activation block
// used by the checker module, no other dependencies
`ifndef SELU_ACTIVATION_FP32_DEFINES_SVH
`define SELU_ACTIVATION_FP32_DEFINES_SVH

// concurrent check, disabled while reset is held
`define SELU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also runs during reset
`define SELU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/selu_pkg.sv =====
// shared types, constants and fp32 arithmetic functions for the selu block
// no dependencies
`timescale 1ns / 1ps

package selu_pkg;

    localparam logic [31:0] QNAN      = 32'h7FC0_0000;
    localparam logic [31:0] ONE       = 32'h3F80_0000;
    localparam logic [31:0] NEG_ONE   = 32'hBF80_0000;
    localparam logic [31:0] TWO       = 32'h4000_0000;
    localparam logic [31:0] LAMBDA    = 32'h3F86_7D56;  // 1.0507
    localparam logic [31:0] ALPHA     = 32'h3FD6_2EB2;  // 1.6733
    localparam logic [31:0] LOG2E     = 32'h3FB8_AA3B;  // 1.442695
    localparam logic [31:0] POLY_A    = 32'h3F56_594B;  // 0.8373
    localparam logic [31:0] POLY_B    = 32'h3F5D_0000;  // 0.86328125
    localparam logic [7:0]  EXP_HALF  = 8'd126;
    localparam logic [7:0]  EXP_ONE   = 8'd127;
    localparam int          SQ_STAGES = 8;
    localparam logic [7:0]  EXP_SAT   = EXP_ONE + 8'(SQ_STAGES - 1);
    localparam int          LATENCY   = 25;

    typedef struct packed {
        logic        pos;   // x >= 0 branch
        logic        neg;   // x < 0, reciprocal needed
        logic [31:0] x;     // flushed input
        logic [31:0] v;     // working value
        logic [31:0] t;     // scratch value
        logic [31:0] r;     // reciprocal estimate
        logic [3:0]  nsq;   // squarings left
    } t_item;

    function automatic logic [31:0] fp_flush(input logic [31:0] b);
        logic [31:0] res;
        res = b;
        if (b[30:23] == 8'h00) begin
            res = {b[31], 31'b0};
        end else if (b[30:23] == 8'hFF && b[22:0] != 23'b0) begin
            res = QNAN;
        end
        return res;
    endfunction

    // round to nearest even, flush tiny results to a signed zero
    function automatic logic [31:0] fp_rnd(input logic s, input logic signed [9:0] e,
                                           input logic [23:0] m, input logic g,
                                           input logic st);
        logic [31:0]        res;
        logic [24:0]        m2;
        logic signed [9:0]  e2;
        logic               inc;
        res = {s, 31'b0};
        m2  = 25'b0;
        e2  = e;
        inc = 1'b0;
        if (e > 10'sd0) begin
            inc = g & (st | m[0]);
            m2  = {1'b0, m} + {24'b0, inc};
            e2  = m2[24] ? e + 10'sd1 : e;
            if (e2 >= 10'sd255) begin
                res = {s, 8'hFF, 23'b0};
            end else begin
                res = {s, e2[7:0], m2[22:0]};
            end
        end else if (e == 10'sd0) begin
            // only a carry up to the smallest normal survives
            inc = m[0] & (g | st | m[1]);
            m2  = {2'b0, m[23:1]} + {24'b0, inc};
            if (m2[23]) begin
                res = {s, 8'd1, 23'b0};
            end
        end
        return res;
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a_in, input logic [31:0] b_in);
        logic [31:0]       a, b, res;
        logic              s, nan_a, nan_b, inf_a, inf_b, zro_a, zro_b;
        logic [47:0]       p;
        logic signed [9:0] e;
        a     = fp_flush(a_in);
        b     = fp_flush(b_in);
        s     = a[31] ^ b[31];
        nan_a = (a == QNAN);
        nan_b = (b == QNAN);
        inf_a = (a[30:0] == 31'h7F80_0000);
        inf_b = (b[30:0] == 31'h7F80_0000);
        zro_a = (a[30:0] == 31'b0);
        zro_b = (b[30:0] == 31'b0);
        p     = 48'({1'b1, a[22:0]}) * 48'({1'b1, b[22:0]});
        e     = $signed({2'b0, a[30:23]}) + $signed({2'b0, b[30:23]}) - 10'sd127;
        if (nan_a || nan_b || (inf_a && zro_b) || (zro_a && inf_b)) begin
            res = QNAN;
        end else if (inf_a || inf_b) begin
            res = {s, 8'hFF, 23'b0};
        end else if (zro_a || zro_b) begin
            res = {s, 31'b0};
        end else if (p[47]) begin
            res = fp_rnd(s, e + 10'sd1, p[47:24], p[23], |p[22:0]);
        end else begin
            res = fp_rnd(s, e, p[46:23], p[22], |p[21:0]);
        end
        return res;
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a_in, input logic [31:0] b_in);
        logic [31:0]       a, b, big, sml, res;
        logic [7:0]        d;
        logic [26:0]       bm, sm, sh, nrm;
        logic              stk;
        logic [27:0]       sum;
        logic [4:0]        lz;
        logic signed [9:0] e;
        a   = fp_flush(a_in);
        b   = fp_flush(b_in);
        big = a;
        sml = b;
        d   = 8'd0;
        bm  = 27'b0;
        sm  = 27'b0;
        sh  = 27'b0;
        nrm = 27'b0;
        stk = 1'b0;
        sum = 28'b0;
        lz  = 5'd0;
        e   = 10'sd0;
        res = 32'b0;
        if (a == QNAN || b == QNAN) begin
            res = QNAN;
        end else if (a[30:0] == 31'h7F80_0000 && b[30:0] == 31'h7F80_0000) begin
            res = (a[31] != b[31]) ? QNAN : a;
        end else if (a[30:0] == 31'h7F80_0000) begin
            res = a;
        end else if (b[30:0] == 31'h7F80_0000) begin
            res = b;
        end else if (a[30:0] == 31'b0 && b[30:0] == 31'b0) begin
            res = {a[31] & b[31], 31'b0};
        end else if (a[30:0] == 31'b0) begin
            res = b;
        end else if (b[30:0] == 31'b0) begin
            res = a;
        end else begin
            if (a[30:0] < b[30:0]) begin
                big = b;
                sml = a;
            end
            d  = big[30:23] - sml[30:23];
            bm = {1'b1, big[22:0], 3'b0};
            sm = {1'b1, sml[22:0], 3'b0};
            if (d >= 8'd27) begin
                sh  = 27'b0;
                stk = 1'b1;
            end else begin
                sh  = sm >> d;
                stk = ((sh << d) != sm);
            end
            sh[0] = sh[0] | stk;
            if (big[31] == sml[31]) begin
                sum = {1'b0, bm} + {1'b0, sh};
            end else begin
                sum = {1'b0, bm} - {1'b0, sh};
            end
            if (sum == 28'b0) begin
                res = 32'b0;
            end else if (sum[27]) begin
                nrm = {sum[27:2], sum[1] | sum[0]};
                e   = $signed({2'b0, big[30:23]}) + 10'sd1;
                res = fp_rnd(big[31], e, nrm[26:3], nrm[2], |nrm[1:0]);
            end else begin
                for (int i = 0; i < 27; i++) begin
                    if (sum[i]) lz = 5'(26 - i);
                end
                nrm = sum[26:0] << lz;
                e   = $signed({2'b0, big[30:23]}) - $signed({5'b0, lz});
                res = fp_rnd(big[31], e, nrm[26:3], nrm[2], |nrm[1:0]);
            end
        end
        return res;
    endfunction

    localparam logic [31:0] LAMBDA_ALPHA = fp_mul(LAMBDA, ALPHA);

endpackage

// ===== rtl/selu_poly.sv =====
// four stage evaluation of the quadratic 0.8373*v*v + 0.86328125*v + 1
// depends on selu_pkg
`timescale 1ns / 1ps

module selu_poly import selu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    input  t_item i_item,
    output logic  o_vld,
    output t_item o_item
);

    logic [3:0] r_vld;
    t_item      r_item [0:3];
    t_item      n_item [0:3];

    always_comb begin
        n_item[0]   = i_item;
        n_item[0].t = fp_mul(i_item.v, POLY_A);
        n_item[1]   = r_item[0];
        n_item[1].t = fp_add(r_item[0].t, POLY_B);
        n_item[2]   = r_item[1];
        n_item[2].t = fp_mul(r_item[1].v, r_item[1].t);
        n_item[3]   = r_item[2];
        n_item[3].v = fp_add(r_item[2].t, ONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 4'b0;
        end else begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_item[i] <= n_item[i];
        end
    end

    assign o_vld  = r_vld[3];
    assign o_item = r_item[3];

endmodule

// ===== rtl/selu_sqr.sv =====
// chain of conditional squaring stages, one fp multiply per stage
// depends on selu_pkg
`timescale 1ns / 1ps

module selu_sqr import selu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    input  t_item i_item,
    output logic  o_vld,
    output t_item o_item
);

    logic [SQ_STAGES-1:0] r_vld;
    t_item                r_item [0:SQ_STAGES-1];
    t_item                n_item [0:SQ_STAGES-1];
    t_item                src    [0:SQ_STAGES-1];

    always_comb begin
        src[0] = i_item;
        for (int i = 1; i < SQ_STAGES; i++) begin
            src[i] = r_item[i-1];
        end
        for (int i = 0; i < SQ_STAGES; i++) begin
            n_item[i] = src[i];
            if (src[i].nsq != 4'd0) begin
                n_item[i].v   = fp_mul(src[i].v, src[i].v);
                n_item[i].nsq = src[i].nsq - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[SQ_STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SQ_STAGES; i++) begin
            r_item[i] <= n_item[i];
        end
    end

    assign o_vld  = r_vld[SQ_STAGES-1];
    assign o_item = r_item[SQ_STAGES-1];

endmodule

// ===== rtl/selu_recip.sv =====
// reciprocal: seed, two newton steps and exponent rebias, ten stages
// depends on selu_pkg
`timescale 1ns / 1ps

module selu_recip import selu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    input  t_item i_item,
    output logic  o_vld,
    output t_item o_item
);

    localparam int NST = 10;

    logic [NST-1:0] r_vld;
    t_item          r_item [0:NST-1];
    t_item          n_item [0:NST-1];

    // negated mantissa scaled into [0.5,1)
    function automatic logic [31:0] neg_mant(input logic [31:0] v);
        return {1'b1, EXP_HALF, v[22:0]};
    endfunction

    function automatic logic [31:0] rebias(input logic [31:0] r, input logic [31:0] v);
        logic signed [9:0] ne;
        logic [31:0]       res;
        ne  = $signed({2'b0, r[30:23]}) - $signed({2'b0, v[30:23]}) + 10'sd126;
        res = {r[31], ne[7:0], r[22:0]};
        if (ne < 10'sd0) res = 32'b0;
        return res;
    endfunction

    always_comb begin
        n_item[0]   = i_item;
        n_item[0].t = fp_mul(neg_mant(i_item.v), LOG2E);
        n_item[1]   = r_item[0];
        n_item[1].t = fp_add(r_item[0].t, TWO);
        n_item[2]   = r_item[1];
        n_item[2].r = fp_mul(LOG2E, r_item[1].t);
        for (int k = 0; k < 2; k++) begin
            n_item[3+3*k]   = r_item[2+3*k];
            n_item[3+3*k].t = fp_mul(neg_mant(r_item[2+3*k].v), r_item[2+3*k].r);
            n_item[4+3*k]   = r_item[3+3*k];
            n_item[4+3*k].t = fp_add(r_item[3+3*k].t, TWO);
            n_item[5+3*k]   = r_item[4+3*k];
            n_item[5+3*k].r = fp_mul(r_item[4+3*k].r, r_item[4+3*k].t);
        end
        n_item[9] = r_item[8];
        if (r_item[8].neg) begin
            n_item[9].v = rebias(r_item[8].r, r_item[8].v);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NST-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NST; i++) begin
            r_item[i] <= n_item[i];
        end
    end

    assign o_vld  = r_vld[NST-1];
    assign o_item = r_item[NST-1];

endmodule

// ===== rtl/selu_activation_fp32.sv =====
// top level of the fp32 selu activation pipeline
// depends on selu_pkg, selu_poly, selu_sqr, selu_recip
`timescale 1ns / 1ps

// selu on one fp32 element per item, fully pipelined: an item may be started
// in every clock cycle and its result appears on o_y_bits with o_valid. the
// path is a chain of single rounding fp multiply and add stages: 1 input
// stage, 4 polynomial stages, 8 squaring stages, 10 reciprocal stages and 2
// output stages. busy is high only while reset is held; the result strobe
// lasts one cycle and cannot be held off, so the receiver must take every
// result when o_valid is high. arithmetic is ieee single precision, round to
// nearest even, with subnormals flushed to zero and every nan produced as
// the canonical quiet nan.

module selu_activation_fp32 import selu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_x_bits,
    output logic        o_valid,
    output logic [31:0] o_y_bits
);

    // input stage
    logic        r_s0_vld;
    t_item       r_s0_item;
    t_item       n_s0_item;
    logic [31:0] n_x;
    logic        n_nan;

    // submodule outputs
    logic  poly_vld, sqr_vld, rcp_vld;
    t_item poly_item, sqr_item, rcp_item;

    // output stages
    logic        r_f1_vld;
    t_item       r_f1_item;
    t_item       n_f1_item;
    logic        r_f2_vld;
    logic [31:0] r_y;
    logic [31:0] n_y;

    assign busy = ~i_rst_n;

    // flush input, pick branch, range reduce and count squarings
    always_comb begin
        n_x             = fp_flush(i_x_bits);
        n_nan           = (n_x == QNAN);
        n_s0_item       = '0;
        n_s0_item.x     = n_x;
        n_s0_item.pos   = !n_nan && (!n_x[31] || n_x[30:0] == 31'b0);
        n_s0_item.neg   = !n_nan && n_x[31] && n_x[30:0] != 31'b0;
        if (n_x[30:23] >= EXP_ONE) begin
            n_s0_item.v = {1'b0, EXP_HALF, n_x[22:0]};
            if (n_x[30:23] >= EXP_SAT) begin
                n_s0_item.nsq = 4'(SQ_STAGES);
            end else begin
                n_s0_item.nsq = 4'(n_x[30:23] - EXP_HALF);
            end
        end else begin
            n_s0_item.v   = {1'b0, n_x[30:0]};
            n_s0_item.nsq = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else begin
            r_s0_vld <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_item <= n_s0_item;
    end

    selu_poly u_poly (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_s0_vld),
        .i_item (r_s0_item),
        .o_vld  (poly_vld),
        .o_item (poly_item)
    );

    selu_sqr u_sqr (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (poly_vld),
        .i_item (poly_item),
        .o_vld  (sqr_vld),
        .o_item (sqr_item)
    );

    selu_recip u_recip (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (sqr_vld),
        .i_item (sqr_item),
        .o_vld  (rcp_vld),
        .o_item (rcp_item)
    );

    // exp minus one, then scale by lambda or lambda*alpha
    always_comb begin
        n_f1_item   = rcp_item;
        n_f1_item.t = fp_add(rcp_item.v, NEG_ONE);
        if (r_f1_item.pos) begin
            n_y = fp_mul(LAMBDA, r_f1_item.x);
        end else begin
            n_y = fp_mul(LAMBDA_ALPHA, r_f1_item.t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
        end else begin
            r_f1_vld <= rcp_vld;
            r_f2_vld <= r_f1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_item <= n_f1_item;
        r_y       <= n_y;
    end

    assign o_valid  = r_f2_vld;
    assign o_y_bits = r_y;

endmodule

// ===== rtl/selu_activation_fp32_chk.sv =====
// port level checker for the selu activation block, bound to the top level
// depends on selu_pkg and selu_activation_fp32_defines.svh
`timescale 1ns / 1ps
`include "selu_activation_fp32_defines.svh"

module selu_activation_fp32_chk import selu_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [31:0] i_x_bits,
    input logic        o_valid,
    input logic [31:0] o_y_bits
);

    logic acc;
    logic nan_in;
    logic ninf_in;

    assign acc     = start && !busy;
    assign nan_in  = i_x_bits[30:23] == 8'hFF && i_x_bits[22:0] != 23'b0;
    assign ninf_in = i_x_bits == 32'hFF80_0000;

    // every started item gives a result strobe, and no strobe comes without a started item
    `SELU_ASSERT(a_lat_fwd, i_clk, i_rst_n, acc |-> ##25 o_valid, "result missing")
    `SELU_ASSERT(a_lat_bwd, i_clk, i_rst_n, o_valid |-> $past(acc, 25), "result invented")
    // negative infinity saturates at minus lambda*alpha
    `SELU_ASSERT(a_neg_inf, i_clk, i_rst_n, (acc && ninf_in) |-> ##25 (o_y_bits == (LAMBDA_ALPHA | 32'h8000_0000)), "bad result for negative infinity")
    // a nan input overflows in the squaring chain and gives plus infinity
    `SELU_ASSERT(a_nan_inf, i_clk, i_rst_n, (acc && nan_in) |-> ##25 (o_y_bits == 32'h7F80_0000), "bad result for nan input")

endmodule

bind selu_activation_fp32 selu_activation_fp32_chk u_chk (.*);
